/* src/assert_macros.svh */
// Assertion macros shared by the checker files of the requantize core.
// Include by bare file name; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that cond never holds at a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* src/fprq_pkg.sv */
// Shared widths, constants and register index codes of the requantize core.
// No dependencies; used by the core and its rounding shifter.
package fprq_pkg;

  localparam int DataW   = 32;
  localparam int ShiftW  = 6;
  localparam int ShAmtW  = 5;
  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMultiplier  = 1'b0,
    CfgShiftAmount = 1'b1
  } cfg_idx_e;

  localparam logic signed [DataW-1:0]   MultReset  = 32'sh4000_0000;
  localparam logic signed [ShiftW-1:0]  ShiftReset = 6'sd0;
  localparam logic signed [ShiftW-1:0]  ShiftMin   = 6'sb100000;
  localparam logic [ShAmtW-1:0]         ShAmtMax   = 5'd31;
  localparam logic signed [DataW-1:0]   DataMin    = 32'sh8000_0000;
  localparam logic signed [DataW-1:0]   DataMax    = 32'sh7FFF_FFFF;
  localparam logic signed [2*DataW-1:0] HmNudge    = 64'sh0000_0000_4000_0000;

endpackage

/* src/fprq_round_shift.sv */
// Rounding arithmetic right shift, halves rounded away from zero.
// Depends on fprq_pkg for widths.
module fprq_round_shift (
  input  logic signed [fprq_pkg::DataW-1:0]  value_i,
  input  logic        [fprq_pkg::ShAmtW-1:0] shamt_i,
  output logic signed [fprq_pkg::DataW-1:0]  value_o
);

  logic        [fprq_pkg::DataW-1:0] mask;
  logic        [fprq_pkg::DataW-1:0] rem;
  logic        [fprq_pkg::DataW-1:0] thr;
  logic signed [fprq_pkg::DataW-1:0] shifted;

  always_comb begin
    mask    = (fprq_pkg::DataW'(1) << shamt_i) - fprq_pkg::DataW'(1);
    rem     = value_i & mask;
    thr     = (mask >> 1) + fprq_pkg::DataW'(value_i[fprq_pkg::DataW-1]);
    shifted = value_i >>> shamt_i;
    value_o = shifted + fprq_pkg::DataW'(rem > thr);
  end

endmodule

/* src/fixed_point_requantize_multiply_core.sv */
// Throughput: one word per cycle while out_stall_i is low; stages are left shift, 32x32
// multiply, nudge and high-half select, rounding right shift into the output register.
// Each stage holds only while the one ahead is full and blocked, so bubbles collapse.
// Reset (asynchronous, active low) empties the pipeline and loads the register reset values.
// Depends on fprq_pkg and fprq_round_shift.
module fixed_point_requantize_multiply_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fprq_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fprq_pkg::DataW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fprq_pkg::DataW-1:0]   value_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fprq_pkg::DataW-1:0]   value_out_o
);

  logic signed [fprq_pkg::DataW-1:0]   multiplier_q;
  logic signed [fprq_pkg::ShiftW-1:0]  shift_amount_q;

  logic                                lsh_en;
  logic        [fprq_pkg::ShAmtW-1:0]  lsh_amt;
  logic        [fprq_pkg::ShAmtW-1:0]  rsh_amt;
  logic signed [fprq_pkg::ShiftW-1:0]  shift_neg;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  logic signed [fprq_pkg::DataW-1:0]   a_d, a_q;
  logic signed [2*fprq_pkg::DataW-1:0] prod_d, prod_q;
  logic                                sat_d, sat_q;
  logic signed [2*fprq_pkg::DataW-1:0] nudged;
  logic signed [fprq_pkg::DataW-1:0]   hm_d, hm_q;
  logic signed [fprq_pkg::DataW-1:0]   res_d, res_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multiplier_q   <= fprq_pkg::MultReset;
      shift_amount_q <= fprq_pkg::ShiftReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (fprq_pkg::cfg_idx_e'(cfg_index_i))
        fprq_pkg::CfgMultiplier:  multiplier_q   <= cfg_wdata_i;
        fprq_pkg::CfgShiftAmount: shift_amount_q <= cfg_wdata_i[fprq_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shift_neg = -shift_amount_q;
    lsh_en    = !shift_amount_q[fprq_pkg::ShiftW-1] && (shift_amount_q != fprq_pkg::ShiftReset);
    lsh_amt   = shift_amount_q[fprq_pkg::ShAmtW-1:0];
    if (!shift_amount_q[fprq_pkg::ShiftW-1]) begin
      rsh_amt = '0;
    end else if (shift_amount_q == fprq_pkg::ShiftMin) begin
      rsh_amt = fprq_pkg::ShAmtMax;
    end else begin
      rsh_amt = shift_neg[fprq_pkg::ShAmtW-1:0];
    end
  end

  assign s4_ready   = !s4_valid_q || !out_stall_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  always_comb begin
    a_d    = lsh_en ? (value_in_i << lsh_amt) : value_in_i;
    prod_d = a_q * multiplier_q;
    sat_d  = (a_q == fprq_pkg::DataMin) && (multiplier_q == fprq_pkg::DataMin);
    nudged = prod_q + fprq_pkg::HmNudge;
    hm_d   = sat_q ? fprq_pkg::DataMax : nudged[2*fprq_pkg::DataW-2:fprq_pkg::DataW-1];
  end

  fprq_round_shift u_round (
    .value_i (hm_q),
    .shamt_i (rsh_amt),
    .value_o (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      a_q <= a_d;
    end
    if (s2_ready && s1_valid_q) begin
      prod_q <= prod_d;
      sat_q  <= sat_d;
    end
    if (s3_ready && s2_valid_q) begin
      hm_q <= hm_d;
    end
    if (s4_ready && s3_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign value_out_o = res_q;

endmodule

/* src/fprq_checker.sv */
// Port-level checker for the requantize core, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fprq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_out_o
);

  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(value_out_o), "stalled output word changed")
  `ASSERT_AT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o, "config port not ready")
  `ASSERT_NEVER(a_in_stall_cause, clk_i, rst_ni, in_stall_o && !(out_valid_o && out_stall_i), "input stalled with output free")
  `ASSERT_AT(a_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 4), "output word without input four cycles earlier")

endmodule

bind fixed_point_requantize_multiply_core fprq_checker u_fprq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_out_o (value_out_o)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for fixed_point_requantize_multiply_core: directed and random words checked
// against an in-bench requantize predictor under varied input gaps and output stalls.
// Depends on fprq_pkg and the core RTL.
module tb_top;

  localparam int     CycleLimit = 200000;
  localparam longint HighDiv    = 64'sd2147483648;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  fprq_pkg::cfg_idx_e                cfg_index_i;
  logic [fprq_pkg::DataW-1:0]        cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [fprq_pkg::DataW-1:0] value_in_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [fprq_pkg::DataW-1:0] value_out_o;

  logic signed [fprq_pkg::DataW-1:0]  cur_mult;
  logic signed [fprq_pkg::ShiftW-1:0] cur_shift;
  logic signed [fprq_pkg::DataW-1:0]  predicted_out_q[$];
  logic signed [fprq_pkg::DataW-1:0]  want_out;
  int                                 in_idle_pct;
  int                                 out_stall_pct;
  int                                 err_cnt;
  int                                 cycle_cnt;

  fixed_point_requantize_multiply_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_in_i (value_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_out_o(value_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic signed [fprq_pkg::DataW-1:0] doubling_high_mul(
    logic signed [fprq_pkg::DataW-1:0] a, logic signed [fprq_pkg::DataW-1:0] b);
    longint prod;
    longint quot;
    if (a == fprq_pkg::DataMin && b == fprq_pkg::DataMin) return fprq_pkg::DataMax;
    prod = longint'(a) * longint'(b);
    quot = (prod + ((prod >= 0) ? fprq_pkg::HmNudge : (64'sd1 - fprq_pkg::HmNudge)))
           / HighDiv;
    return quot[fprq_pkg::DataW-1:0];
  endfunction

  function automatic logic signed [fprq_pkg::DataW-1:0] round_shift_right(
    logic signed [fprq_pkg::DataW-1:0] x, int sh);
    logic [fprq_pkg::DataW-1:0] mask;
    logic [fprq_pkg::DataW-1:0] rem;
    logic [fprq_pkg::DataW-1:0] thr;
    mask = 32'((64'd1 << sh) - 64'd1);
    rem  = x & mask;
    thr  = (mask >> 1) + ((x < 0) ? 32'd1 : 32'd0);
    return (x >>> sh) + ((rem > thr) ? 32'sd1 : 32'sd0);
  endfunction

  function automatic logic signed [fprq_pkg::DataW-1:0] requantize_value(
    logic signed [fprq_pkg::DataW-1:0] x);
    logic signed [fprq_pkg::DataW-1:0] shifted;
    int                                rsh;
    if (cur_shift > 0) begin
      shifted = x << cur_shift;
      return doubling_high_mul(shifted, cur_mult);
    end
    rsh = -int'(cur_shift);
    if (rsh > 31) rsh = 31;
    return round_shift_right(doubling_high_mul(x, cur_mult), rsh);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_out_q.size() == 0) begin
        $display("%0t unexpected word: expected none, got %0d", $time, value_out_o);
        err_cnt++;
      end else begin
        want_out = predicted_out_q.pop_front();
        if (value_out_o !== want_out) begin
          $display("%0t value_out mismatch: expected %0d, got %0d",
                   $time, want_out, value_out_o);
          err_cnt++;
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < out_stall_pct);
  end

  task automatic send_value(logic signed [fprq_pkg::DataW-1:0] x);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    predicted_out_q.push_back(requantize_value(x));
  endtask

  // drop valid and drain the pipe
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (predicted_out_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(fprq_pkg::cfg_idx_e idx, logic [fprq_pkg::DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fprq_pkg::CfgMultiplier:  cur_mult  = data;
      fprq_pkg::CfgShiftAmount: cur_shift = data[fprq_pkg::ShiftW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic signed [fprq_pkg::DataW-1:0] mult,
                            logic signed [fprq_pkg::ShiftW-1:0] sh);
    settle();
    write_reg(fprq_pkg::CfgMultiplier, mult);
    write_reg(fprq_pkg::CfgShiftAmount,
              {{(fprq_pkg::DataW-fprq_pkg::ShiftW){sh[fprq_pkg::ShiftW-1]}}, sh});
  endtask

  function automatic logic signed [fprq_pkg::DataW-1:0] random_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 2000) - 1000;
      1: begin
        case ($urandom_range(0, 3))
          0: return fprq_pkg::DataMin;
          1: return fprq_pkg::DataMax;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      2: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [fprq_pkg::DataW-1:0] random_mult();
    case ($urandom_range(0, 9))
      0: return fprq_pkg::DataMin;
      1: return fprq_pkg::DataMax;
      2: return 32'sd0;
      3: return fprq_pkg::MultReset;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_config();
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sd3);
    send_value(-32'sd3);
    send_value(fprq_pkg::DataMax);
    send_value(fprq_pkg::DataMin);
  endtask

  task automatic test_min_saturation();
    set_config(fprq_pkg::DataMin, 6'sd0);
    send_value(fprq_pkg::DataMin);
    send_value(fprq_pkg::DataMax);
    send_value(-32'sd1);
    send_value(32'sd1);
    set_config(fprq_pkg::DataMin, 6'sd1);
    send_value(32'shC000_0000);
  endtask

  task automatic test_left_shift_wrap();
    set_config(fprq_pkg::DataMax, 6'sd31);
    send_value(32'sd1);
    send_value(32'sd3);
    send_value(-32'sd1);
    set_config(fprq_pkg::MultReset, 6'sd1);
    send_value(32'sh4000_0001);
  endtask

  task automatic test_right_shift_extremes();
    set_config(fprq_pkg::DataMax, -6'sd31);
    send_value(fprq_pkg::DataMax);
    send_value(fprq_pkg::DataMin);
    send_value(32'sd2);
    set_config(fprq_pkg::DataMax, fprq_pkg::ShiftMin);
    send_value(fprq_pkg::DataMax);
    send_value(fprq_pkg::DataMin);
    set_config(fprq_pkg::MultReset, -6'sd1);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sd3);
  endtask

  task automatic test_random(int idle_pct, int stall_pct);
    settle();
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (5) begin
      set_config(random_mult(), 6'($urandom_range(0, 63)));
      repeat (25) send_value(random_value());
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= fprq_pkg::CfgMultiplier;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    value_in_i    <= '0;
    cur_mult       = fprq_pkg::MultReset;
    cur_shift      = fprq_pkg::ShiftReset;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_min_saturation();
    test_left_shift_wrap();
    test_right_shift_extremes();
    test_random(0, 0);
    test_random(54, 0);
    test_random(0, 54);
    test_random(9, 9);

    settle();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
